// ----- hdl/mrdpe_pkg.sv -----
// Shared types and constants for the mixed-radix domain point encoder.
package mrdpe_pkg;

	localparam int IDX_W      = 32;
	localparam int ENC_W      = 64;
	localparam int DS_W       = 33;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int FIELD_W    = 7;
	localparam int CNT_W      = 2;
	localparam int PORT_REGS  = 2;
	localparam int PSEL_W     = 1;
	localparam int BITS_W     = 15;
	localparam int POS_W      = 8;
	localparam int DIV_CNT_W  = $clog2(IDX_W);

	typedef enum logic [1:0] {
		FAM_ONEHOT,
		FAM_BIN_MSB,
		FAM_BIN_LSB,
		FAM_RAW
	} fam_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CARD,
		ST_CHECK,
		ST_PORT,
		ST_DIV,
		ST_BIT,
		ST_DONE
	} state_t;

	localparam logic [CFG_IDX_W-1:0] REG_PORT_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_P0_FAMILY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P0_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P0_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_P1_FAMILY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_P1_WIDTH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_P1_COUNT   = 3'd6;

	localparam logic [CNT_W-1:0]   RST_PORT_COUNT = 2'd1;
	localparam fam_t               RST_FAMILY     = FAM_BIN_MSB;
	localparam logic [FIELD_W-1:0] RST_WIDTH      = 7'd8;
	localparam logic [FIELD_W-1:0] RST_COUNT      = 7'd1;

	typedef struct packed {
		logic               start;
		logic [IDX_W-1:0]   dividend;
		logic [FIELD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [IDX_W-1:0]   quotient;
		logic [FIELD_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ----- hdl/mrdpe_ifs.sv -----
// Handshake channel interfaces: point input, code output, configuration writes.
interface mrdpe_point_if;
	logic                         valid;
	logic                         ready;
	logic [mrdpe_pkg::IDX_W-1:0]  point_index;
	modport source (output valid, output point_index, input ready);
	modport sink (input valid, input point_index, output ready);
endinterface

interface mrdpe_code_if;
	logic                         valid;
	logic                         ready;
	logic [mrdpe_pkg::ENC_W-1:0]  encoded_bits;
	logic                         encode_ok;
	logic [mrdpe_pkg::DS_W-1:0]   domain_size;
	modport source (output valid, output encoded_bits, output encode_ok,
		output domain_size, input ready);
	modport sink (input valid, input encoded_bits, input encode_ok,
		input domain_size, output ready);
endinterface

interface mrdpe_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mrdpe_pkg::CFG_IDX_W-1:0]   index;
	logic [mrdpe_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/mrdpe_div.sv -----
// Restoring divider, one quotient bit per cycle, index by field radix.
module mrdpe_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mrdpe_pkg::div_req_t req,
	output mrdpe_pkg::div_rsp_t rsp
);

	localparam logic [mrdpe_pkg::DIV_CNT_W-1:0] LAST_STEP =
		mrdpe_pkg::DIV_CNT_W'(mrdpe_pkg::IDX_W - 1);

	logic                              busy_q;
	logic                              done_q;
	logic [mrdpe_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [mrdpe_pkg::FIELD_W-1:0]     dsr_q;
	logic [mrdpe_pkg::FIELD_W-1:0]     rem_q;
	logic [mrdpe_pkg::IDX_W-1:0]       quo_q;

	logic [mrdpe_pkg::FIELD_W:0]       shifted;
	logic [mrdpe_pkg::FIELD_W:0]       diff;
	logic                              ge;

	always_comb begin
		shifted = {rem_q, quo_q[mrdpe_pkg::IDX_W-1]};
		diff    = shifted - {1'b0, dsr_q};
		ge      = shifted >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dsr_q <= req.divisor;
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[mrdpe_pkg::FIELD_W-1:0] : shifted[mrdpe_pkg::FIELD_W-1:0];
			quo_q <= {quo_q[mrdpe_pkg::IDX_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dsr_q)
		else $error("remainder not below divisor");

	a_no_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without a running division");

endmodule

// ----- hdl/mixed_radix_domain_point_encoder.sv -----
// Top level: mixed-radix domain point encoder with configuration registers.
//
//  channel | dir | transfer carries
//  cfg     | in  | index, data            register write, always ready
//  point   | in  | point_index            one item per result
//  code    | out | encoded_bits, encode_ok, domain_size
//
// One item at a time. Each item is accepted, then the cardinality is built in F steps (one per
// field over the ports in use, multiply or shift and compare) and checked, then per
// port a setup step plus one shared-divider run per one-hot field
// or one step per binary bit, and finally the output register is loaded.
// Invalid configurations and range failures cut the sequence short.
// A finished result waits in the output register while the next item is taken.
// Reset clears configuration to its defaults and empties the output register.
module mixed_radix_domain_point_encoder #(
	parameter int MAX_PORTS   = 2,
	parameter int VECTOR_BITS = 64,
	parameter int INDEX_BITS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	mrdpe_cfg_if.sink     cfg,
	mrdpe_point_if.sink   point,
	mrdpe_code_if.source  code
);

	localparam int IW = INDEX_BITS + 1;
	localparam int PW = 2 * IW;
	localparam int MW = IW + mrdpe_pkg::FIELD_W;
	localparam int CW = (IW > mrdpe_pkg::IDX_W) ? IW : mrdpe_pkg::IDX_W;
	localparam int SW = 2 * mrdpe_pkg::FIELD_W;
	localparam logic [PW-1:0] LIM = PW'(1) << INDEX_BITS;

	// configuration
	logic [mrdpe_pkg::CNT_W-1:0]   port_count_q;
	mrdpe_pkg::fam_t               fam_q [mrdpe_pkg::PORT_REGS];
	logic [mrdpe_pkg::FIELD_W-1:0] fw_q  [mrdpe_pkg::PORT_REGS];
	logic [mrdpe_pkg::FIELD_W-1:0] fc_q  [mrdpe_pkg::PORT_REGS];

	// sequencer and datapath
	mrdpe_pkg::state_t             state_q, state_d;
	logic [mrdpe_pkg::PSEL_W-1:0]  port_q;
	logic [mrdpe_pkg::FIELD_W-1:0] fld_q;
	logic [mrdpe_pkg::FIELD_W-1:0] cnt_q;
	logic [IW-1:0]                 total_q;
	logic [mrdpe_pkg::BITS_W-1:0]  bits_q;
	logic [mrdpe_pkg::IDX_W-1:0]   index_q;
	logic [VECTOR_BITS-1:0]        vec_q;
	logic                          ok_q;
	logic [mrdpe_pkg::POS_W-1:0]   off_q, pos_q, step_q;

	// output register
	logic                          out_valid_q;
	logic [mrdpe_pkg::ENC_W-1:0]   out_vec_q;
	logic                          out_ok_q;
	logic [mrdpe_pkg::DS_W-1:0]    out_dsize_q;

	mrdpe_pkg::div_req_t           div_req;
	mrdpe_pkg::div_rsp_t           div_rsp;

	mrdpe_pkg::fam_t               fam_sel;
	logic [mrdpe_pkg::FIELD_W-1:0] fw_sel, fc_sel;
	logic [mrdpe_pkg::PORT_REGS-1:0] port_ok;
	logic                          cfg_ok;
	logic                          onehot;
	logic                          last_port, last_field, last_step;
	logic [MW-1:0]                 mul;
	logic [PW-1:0]                 prod;
	logic                          over;
	logic                          range_fail;
	logic [SW-1:0]                 slice;
	logic [mrdpe_pkg::POS_W-1:0]   slice_pos;
	logic                          accept, out_free;
	logic                          set_en;
	logic [mrdpe_pkg::POS_W-1:0]   set_pos;
	logic [VECTOR_BITS-1:0]        set_mask;

	mrdpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_count_q <= mrdpe_pkg::RST_PORT_COUNT;
			for (int p = 0; p < mrdpe_pkg::PORT_REGS; p++) begin
				fam_q[p] <= mrdpe_pkg::RST_FAMILY;
				fw_q[p]  <= mrdpe_pkg::RST_WIDTH;
				fc_q[p]  <= mrdpe_pkg::RST_COUNT;
			end
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mrdpe_pkg::REG_PORT_COUNT: port_count_q <= cfg.data[mrdpe_pkg::CNT_W-1:0];
				mrdpe_pkg::REG_P0_FAMILY:  fam_q[0] <= mrdpe_pkg::fam_t'(cfg.data[1:0]);
				mrdpe_pkg::REG_P0_WIDTH:   fw_q[0]  <= cfg.data;
				mrdpe_pkg::REG_P0_COUNT:   fc_q[0]  <= cfg.data;
				mrdpe_pkg::REG_P1_FAMILY:  fam_q[1] <= mrdpe_pkg::fam_t'(cfg.data[1:0]);
				mrdpe_pkg::REG_P1_WIDTH:   fw_q[1]  <= cfg.data;
				mrdpe_pkg::REG_P1_COUNT:   fc_q[1]  <= cfg.data;
				default: ;
			endcase
		end
	end

	// per-port and overall enumerability
	always_comb begin
		for (int p = 0; p < mrdpe_pkg::PORT_REGS; p++) begin
			unique case (fam_q[p]) inside
				mrdpe_pkg::FAM_ONEHOT:
					port_ok[p] = (fw_q[p] != '0) && (fc_q[p] != '0);
				mrdpe_pkg::FAM_BIN_MSB, mrdpe_pkg::FAM_BIN_LSB:
					port_ok[p] = (fw_q[p] != '0) && (int'(fw_q[p]) < 64) && (fc_q[p] != '0);
				default:
					port_ok[p] = 1'b0;
			endcase
		end
		cfg_ok = (port_count_q != '0) && (int'(port_count_q) <= MAX_PORTS)
			&& (int'(port_count_q) <= mrdpe_pkg::PORT_REGS) && port_ok[0]
			&& ((int'(port_count_q) < 2) || port_ok[1]);
	end

	// shared multiply/shift-compare and position arithmetic
	always_comb begin
		fam_sel    = fam_q[port_q];
		fw_sel     = fw_q[port_q];
		fc_sel     = fc_q[port_q];
		onehot     = fam_sel == mrdpe_pkg::FAM_ONEHOT;
		last_port  = (mrdpe_pkg::CNT_W'(port_q) + mrdpe_pkg::CNT_W'(1)) == port_count_q;
		last_field = (fld_q + 1'b1) == fc_sel;
		last_step  = cnt_q == mrdpe_pkg::FIELD_W'(1);
		mul        = MW'(total_q) * MW'(fw_sel);
		prod       = onehot ? PW'(mul) : (PW'(total_q) << fw_sel[mrdpe_pkg::FIELD_W-2:0]);
		over       = (prod > LIM) || (!onehot && (int'(fw_sel) > INDEX_BITS));
		range_fail = (int'(bits_q) > VECTOR_BITS) || (CW'(index_q) >= CW'(total_q));
		slice      = SW'(fw_sel) * SW'(fc_sel);
		slice_pos  = slice[mrdpe_pkg::POS_W-1:0];
		accept     = point.valid && point.ready;
		out_free   = !out_valid_q || code.ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrdpe_pkg::ST_IDLE:
				if (accept) state_d = cfg_ok ? mrdpe_pkg::ST_CARD : mrdpe_pkg::ST_DONE;
			mrdpe_pkg::ST_CARD:
				if (over) state_d = mrdpe_pkg::ST_DONE;
				else if (last_field && last_port) state_d = mrdpe_pkg::ST_CHECK;
			mrdpe_pkg::ST_CHECK:
				state_d = range_fail ? mrdpe_pkg::ST_DONE : mrdpe_pkg::ST_PORT;
			mrdpe_pkg::ST_PORT:
				state_d = onehot ? mrdpe_pkg::ST_DIV : mrdpe_pkg::ST_BIT;
			mrdpe_pkg::ST_DIV:
				if (div_rsp.done && last_step)
					state_d = last_port ? mrdpe_pkg::ST_DONE : mrdpe_pkg::ST_PORT;
			mrdpe_pkg::ST_BIT:
				if (last_step)
					state_d = last_port ? mrdpe_pkg::ST_DONE : mrdpe_pkg::ST_PORT;
			mrdpe_pkg::ST_DONE:
				if (out_free) state_d = mrdpe_pkg::ST_IDLE;
			default:
				state_d = mrdpe_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		point.ready      = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = index_q;
		div_req.divisor  = fw_sel;
		set_en           = 1'b0;
		set_pos          = pos_q;
		unique case (state_q)
			mrdpe_pkg::ST_IDLE:
				point.ready = 1'b1;
			mrdpe_pkg::ST_PORT:
				div_req.start = onehot;
			mrdpe_pkg::ST_DIV: begin
				// chain the next field straight off the quotient
				div_req.dividend = div_rsp.quotient;
				div_req.start    = div_rsp.done && !last_step;
				set_en           = div_rsp.done;
				set_pos          = pos_q + mrdpe_pkg::POS_W'(div_rsp.remainder);
			end
			mrdpe_pkg::ST_BIT:
				set_en = index_q[0];
			default: ;
		endcase
		for (int i = 0; i < VECTOR_BITS; i++)
			set_mask[i] = set_en && (set_pos == mrdpe_pkg::POS_W'(i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrdpe_pkg::ST_IDLE;
			port_q  <= '0;
			fld_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				mrdpe_pkg::ST_IDLE:
					if (accept) begin
						port_q <= '0;
						fld_q  <= '0;
					end
				mrdpe_pkg::ST_CARD:
					if (!over) begin
						if (last_field) begin
							fld_q  <= '0;
							port_q <= port_q + 1'b1;
						end else begin
							fld_q <= fld_q + 1'b1;
						end
					end
				mrdpe_pkg::ST_CHECK:
					port_q <= '0;
				mrdpe_pkg::ST_PORT:
					cnt_q <= onehot ? fc_sel : slice[mrdpe_pkg::FIELD_W-1:0];
				mrdpe_pkg::ST_DIV:
					if (div_rsp.done) begin
						cnt_q <= cnt_q - 1'b1;
						if (last_step) port_q <= port_q + 1'b1;
					end
				mrdpe_pkg::ST_BIT: begin
					cnt_q <= cnt_q - 1'b1;
					if (last_step) port_q <= port_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mrdpe_pkg::ST_IDLE && accept) begin
			vec_q <= '0;
		end else begin
			vec_q <= vec_q | set_mask;
		end
		case (state_q)
			mrdpe_pkg::ST_IDLE:
				if (accept) begin
					index_q <= point.point_index;
					total_q <= cfg_ok ? IW'(1) : '0;
					bits_q  <= '0;
					ok_q    <= 1'b0;
				end
			mrdpe_pkg::ST_CARD:
				if (over) begin
					total_q <= '0;
				end else begin
					total_q <= prod[IW-1:0];
					bits_q  <= bits_q + mrdpe_pkg::BITS_W'(fw_sel);
				end
			mrdpe_pkg::ST_CHECK:
				off_q <= '0;
			mrdpe_pkg::ST_PORT: begin
				off_q <= off_q + slice_pos;
				case (fam_sel)
					mrdpe_pkg::FAM_ONEHOT: begin
						// field 0 is the most significant digit, so walk downward
						pos_q  <= off_q + slice_pos - mrdpe_pkg::POS_W'(fw_sel);
						step_q <= '0 - mrdpe_pkg::POS_W'(fw_sel);
					end
					mrdpe_pkg::FAM_BIN_MSB: begin
						pos_q  <= off_q + slice_pos - 1'b1;
						step_q <= '1;
					end
					default: begin
						pos_q  <= off_q;
						step_q <= mrdpe_pkg::POS_W'(1);
					end
				endcase
			end
			mrdpe_pkg::ST_DIV:
				if (div_rsp.done) begin
					index_q <= div_rsp.quotient;
					pos_q   <= pos_q + step_q;
					if (last_step && last_port) ok_q <= 1'b1;
				end
			mrdpe_pkg::ST_BIT: begin
				index_q <= index_q >> 1;
				pos_q   <= pos_q + step_q;
				if (last_step && last_port) ok_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == mrdpe_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (code.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mrdpe_pkg::ST_DONE && out_free) begin
			out_vec_q   <= ok_q ? mrdpe_pkg::ENC_W'(vec_q) : '0;
			out_ok_q    <= ok_q;
			out_dsize_q <= mrdpe_pkg::DS_W'(total_q);
		end
	end

	assign code.valid        = out_valid_q;
	assign code.encoded_bits = out_vec_q;
	assign code.encode_ok    = out_ok_q;
	assign code.domain_size  = out_dsize_q;

	a_fail_zero_bits: assert property (@(posedge clk) disable iff (!arst_n)
		code.valid && !code.encode_ok |-> code.encoded_bits == '0)
		else $error("failed encoding carries set bits");

	a_ok_has_domain: assert property (@(posedge clk) disable iff (!arst_n)
		code.valid && code.encode_ok |-> code.domain_size != '0)
		else $error("valid encoding with empty domain");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.ready |=> !point.ready)
		else $error("ready straight after a transfer");

	a_pos_in_vector: assert property (@(posedge clk) disable iff (!arst_n)
		set_en |-> int'(set_pos) < VECTOR_BITS)
		else $error("bit position outside vector");

endmodule
